>>> rtl/core/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Types, formats and constants shared by the axis-angle rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package aavr_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 20;
  localparam int unsigned AxisW  = 18;
  localparam int unsigned CordW  = 34;
  localparam int unsigned TableLen = 24;

  localparam logic [1:0] REG_AXIS_X = 2'd0;
  localparam logic [1:0] REG_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;

  localparam logic signed [AxisW-1:0] AXIS_X_RST = 18'sd0;
  localparam logic signed [AxisW-1:0] AXIS_Y_RST = 18'sd0;
  localparam logic signed [AxisW-1:0] AXIS_Z_RST = 18'sd65536;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CordW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic signed [CoordW-1:0] vec_x;
    logic signed [CoordW-1:0] vec_y;
    logic signed [CoordW-1:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rot_x;
    logic signed [CoordW-1:0] rot_y;
    logic signed [CoordW-1:0] rot_z;
  } out_t;

  // one cordic cell's worth of state, plus the vector riding along
  typedef struct packed {
    logic                     neg;
    logic signed [CordW-1:0]  x;
    logic signed [CordW-1:0]  y;
    logic signed [CordW-1:0]  z;
    logic signed [CoordW-1:0] vx;
    logic signed [CoordW-1:0] vy;
    logic signed [CoordW-1:0] vz;
  } cordic_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordW-1:0] r;
    case (idx)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048576;
      5'd11:   r = 34'sd524288;
      5'd12:   r = 34'sd262144;
      5'd13:   r = 34'sd131072;
      5'd14:   r = 34'sd65536;
      5'd15:   r = 34'sd32768;
      5'd16:   r = 34'sd16384;
      5'd17:   r = 34'sd8192;
      5'd18:   r = 34'sd4096;
      5'd19:   r = 34'sd2048;
      5'd20:   r = 34'sd1024;
      5'd21:   r = 34'sd512;
      5'd22:   r = 34'sd256;
      5'd23:   r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/aavr_cordic_cell.sv
// ----------------------------------------------------------------------------
// aavr_cordic_cell
// One rotation-mode cordic micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire aavr_pkg::cordic_t data_i,
  output logic                 valid_o,
  output aavr_pkg::cordic_t    data_o
);
  import aavr_pkg::*;

  logic              valid_q;
  cordic_t           data_q, data_d;
  logic signed [CordW-1:0] dx, dy, at;

  always_comb begin
    dx = data_i.y >>> STAGE;
    dy = data_i.x >>> STAGE;
    at = atan_q30(5'(STAGE));
    data_d = data_i;
    if (!data_i.z[CordW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/core/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// Rodrigues rotation of a Q15.16 vector about a configured Q1.16 axis.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the output is
// not stalled. Each transaction passes through the chain of cordic cells (one
// micro-rotation per cell) followed by the matrix build and the split 3x3
// matrix-vector multiply. A stall on the output freezes the whole pipeline.
// The axis registers should be written only while the pipe is empty.
`default_nettype none

module axis_angle_vector_rotation #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [17:0]     cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire aavr_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output aavr_pkg::out_t       out_data_o
);
  import aavr_pkg::*;

  localparam int unsigned NCELL = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // axis registers and config-derived terms
  logic signed [AxisW-1:0] axis_q [3];
  logic signed [35:0] prod_q [3][3];
  logic signed [38:0] c2_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q[0] <= AXIS_X_RST;
      axis_q[1] <= AXIS_Y_RST;
      axis_q[2] <= AXIS_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AXIS_X: axis_q[0] <= cfg_data_i;
        REG_AXIS_Y: axis_q[1] <= cfg_data_i;
        REG_AXIS_Z: axis_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [38:0] nsq;
    nsq = 39'(prod_q[0][0]) + 39'(prod_q[1][1]) + 39'(prod_q[2][2]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= 36'(axis_q[i]) * 36'(axis_q[j]);
        c2_q[i][j]   <= (i == j) ? 39'(prod_q[i][j]) - nsq : 39'(prod_q[i][j]);
      end
    end
  end

  // cross-product matrix of the axis
  logic signed [18:0] c_mat [3][3];
  always_comb begin
    c_mat[0][0] = '0;
    c_mat[0][1] = -19'(axis_q[2]);
    c_mat[0][2] = 19'(axis_q[1]);
    c_mat[1][0] = 19'(axis_q[2]);
    c_mat[1][1] = '0;
    c_mat[1][2] = -19'(axis_q[0]);
    c_mat[2][0] = -19'(axis_q[1]);
    c_mat[2][1] = 19'(axis_q[0]);
    c_mat[2][2] = '0;
  end

  // angle range reduction into the first cell
  logic signed [35:0] a0, a1, a2;
  cordic_t chain_d [NCELL+1];
  logic    chain_v [NCELL+1];

  always_comb begin
    a0 = {{2{in_data_i.angle[AngleW-1]}}, in_data_i.angle, 14'b0};
    if (a0 > PI_Q30) begin
      a1 = a0 - TWO_PI_Q30;
    end else if (a0 < -PI_Q30) begin
      a1 = a0 + TWO_PI_Q30;
    end else begin
      a1 = a0;
    end
    chain_d[0].neg = 1'b0;
    if (a1 > HALF_PI_Q30) begin
      a2 = a1 - PI_Q30;
      chain_d[0].neg = 1'b1;
    end else if (a1 < -HALF_PI_Q30) begin
      a2 = a1 + PI_Q30;
      chain_d[0].neg = 1'b1;
    end else begin
      a2 = a1;
    end
    chain_d[0].x  = GAIN_Q30;
    chain_d[0].y  = '0;
    chain_d[0].z  = a2[CordW-1:0];
    chain_d[0].vx = in_data_i.vec_x;
    chain_d[0].vy = in_data_i.vec_y;
    chain_d[0].vz = in_data_i.vec_z;
    chain_v[0]    = in_valid_i;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    aavr_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  // pipeline stages after the cordic
  logic sc_v_q, p1_v_q, p2_v_q, p3_v_q, p4_v_q, out_v_q;
  logic signed [27:0] s24_q, w24_q;
  logic signed [CoordW-1:0] vec1_q [3], vec2_q [3];
  logic signed [CoordW-1:0] vec0_q [3];
  logic signed [46:0] cs_q [3][3];
  logic signed [47:0] c2lo_q [3][3], c2hi_q [3][3];
  logic signed [31:0] m_q [3][3];
  logic signed [47:0] pa_q [3][3];
  logic signed [48:0] pb_q [3][3];
  logic signed [49:0] asum_q [3];
  logic signed [34:0] qsum_q [3];
  out_t out_q;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [50:0] v);
    logic signed [50:0] hi, lo;
    hi = 51'sd2147483647;
    lo = -51'sd2147483648;
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q  <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sc_v_q  <= chain_v[NCELL];
      p1_v_q  <= sc_v_q;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      out_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CordW:0] sn, cs;
    logic signed [CordW:0] cs24;
    logic signed [67:0] t;
    logic signed [47:0] rs;
    logic signed [35:0] rw;
    logic signed [15:0] vh;
    logic signed [16:0] vl;
    logic signed [49:0] as;
    logic signed [50:0] bs;
    logic signed [50:0] r;
    if (en) begin
      // sine and cosine rounded to q24
      sn = chain_d[NCELL].neg ? -(35'(chain_d[NCELL].y)) : 35'(chain_d[NCELL].y);
      cs = chain_d[NCELL].neg ? -(35'(chain_d[NCELL].x)) : 35'(chain_d[NCELL].x);
      cs24 = (cs + 35'sd32) >>> 6;
      s24_q <= 28'((sn + 35'sd32) >>> 6);
      w24_q <= 28'(35'sd16777216 - cs24);
      vec0_q[0] <= chain_d[NCELL].vx;
      vec0_q[1] <= chain_d[NCELL].vy;
      vec0_q[2] <= chain_d[NCELL].vz;

      // matrix term products, c2 split in two halves
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cs_q[i][j]   <= 47'(c_mat[i][j]) * 47'(s24_q);
          c2lo_q[i][j] <= 48'($signed({1'b0, c2_q[i][j][18:0]})) * 48'(w24_q);
          c2hi_q[i][j] <= 48'(c2_q[i][j] >>> 19) * 48'(w24_q);
        end
        vec1_q[i] <= vec0_q[i];
      end

      // matrix entries in q24
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t  = (68'(c2hi_q[i][j]) <<< 19) + 68'(c2lo_q[i][j]);
          rw = 36'((t + 68'sh80000000) >>> 32);
          rs = (48'(cs_q[i][j]) + 48'sd32768) >>> 16;
          m_q[i][j] <= ((i == j) ? ONE_Q24 : 32'sd0) + 32'(rs) + 32'(rw);
        end
        vec2_q[i] <= vec1_q[i];
      end

      // matrix times vector, each coordinate split high and low
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          vh = vec2_q[j][CoordW-1:16];
          vl = $signed({1'b0, vec2_q[j][15:0]});
          pa_q[i][j] <= 48'(m_q[i][j]) * 48'(vh);
          pb_q[i][j] <= 49'(m_q[i][j]) * 49'(vl);
        end
      end

      for (int i = 0; i < 3; i++) begin
        as = 50'(pa_q[i][0]) + 50'(pa_q[i][1]) + 50'(pa_q[i][2]);
        bs = 51'(pb_q[i][0]) + 51'(pb_q[i][1]) + 51'(pb_q[i][2]) + 51'sd8388608;
        asum_q[i] <= as;
        qsum_q[i] <= 35'(bs >>> 16);
      end

      // final rounding and saturation
      r = (51'(asum_q[0]) + 51'(qsum_q[0])) >>> 8;
      out_q.rot_x <= sat(r);
      r = (51'(asum_q[1]) + 51'(qsum_q[1])) >>> 8;
      out_q.rot_y <= sat(r);
      r = (51'(asum_q[2]) + 51'(qsum_q[2])) >>> 8;
      out_q.rot_z <= sat(r);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/aavr_checker.sv
// ----------------------------------------------------------------------------
// aavr_checker
// Port-level assertions for the axis-angle rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped under stall");

  // the input side only backs up when a result is stuck on the output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a free output never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind axis_angle_vector_rotation aavr_checker u_aavr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire

>>> tb/tb_axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotation
// Self-checking bench for the axis-angle vector rotation pipeline.
// ----------------------------------------------------------------------------
// Vectors and angles are pushed through the valid/stall input channel while a
// local fixed-point model of the rotation predicts each result. Rotated
// vectors are compared in order against the model. Several axis settings are
// loaded between phases, and both channels idle at varying rates.
`default_nettype none

module tb_axis_angle_vector_rotation;
  timeunit 1ns;
  timeprecision 1ps;
  import aavr_pkg::*;

  localparam int unsigned Stages   = 16;
  localparam int unsigned Latency  = Stages + 6;
  localparam int unsigned WdogMax  = 20000;
  localparam longint      PiQ30    = 64'sd3373259426;
  localparam longint      HPiQ30   = 64'sd1686629713;
  localparam longint      TwoPiQ30 = 64'sd6746518852;
  localparam longint      GainQ30  = 64'sd652032874;
  localparam longint      OneQ24   = 64'sd16777216;
  localparam int          AngMax   = 411775;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [17:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;

  axis_angle_vector_rotation #(.CORDIC_STAGES(Stages)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_t     pending_q[$];
  out_t    rotated_q[$];
  longint  axis[3];
  int      src_idle_pct;
  int      dst_stall_pct;
  int      n_errors;
  int      n_sent;
  int      n_checked;
  int      wdog;
  logic    in_acc;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint asr_rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                      2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic out_t rotate_vec(in_t it);
    longint a, x, y, z, dx, dy, sn, cs, s24, w24, nsq, hi, lo, c2, ah, bl, r;
    longint u[3], v[3], cm[3][3], m[3][3];
    logic   neg;
    out_t   res;
    neg = 1'b0;
    a = longint'(it.angle) * 16384;
    while (a > PiQ30) a -= TwoPiQ30;
    while (a < -PiQ30) a += TwoPiQ30;
    if (a > HPiQ30) begin
      a -= PiQ30;
      neg = 1'b1;
    end else if (a < -HPiQ30) begin
      a += PiQ30;
      neg = 1'b1;
    end
    x = GainQ30;
    y = 0;
    z = a;
    for (int i = 0; i < Stages && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_tab(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_tab(i));
      end
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
    s24 = asr_rnd(sn, 6);
    w24 = OneQ24 - asr_rnd(cs, 6);
    u = axis;
    v[0] = longint'(it.vec_x);
    v[1] = longint'(it.vec_y);
    v[2] = longint'(it.vec_z);
    cm[0][0] = 0;     cm[0][1] = -u[2]; cm[0][2] = u[1];
    cm[1][0] = u[2];  cm[1][1] = 0;     cm[1][2] = -u[0];
    cm[2][0] = -u[1]; cm[2][1] = u[0];  cm[2][2] = 0;
    nsq = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c2 = u[i] * u[j] - ((i == j) ? nsq : 0);
        m[i][j] = ((i == j) ? OneQ24 : 0) + asr_rnd(cm[i][j] * s24, 16)
                  + asr_rnd(c2 * w24, 32);
      end
    end
    hi = 64'sd2147483647;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++) begin
      // split each coordinate so the products stay within 64 bits
      ah = 0;
      bl = 0;
      for (int j = 0; j < 3; j++) begin
        ah += m[i][j] * asr(v[j], 16);
        bl += m[i][j] * (v[j] - asr(v[j], 16) * 65536);
      end
      bl += 64'sd1 <<< 23;
      r = asr(ah + asr(bl, 16), 8);
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      case (i)
        0: res.rot_x = r[31:0];
        1: res.rot_y = r[31:0];
        default: res.rot_z = r[31:0];
      endcase
    end
    return res;
  endfunction

  // driver: fed from pending_q, changes at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < dst_stall_pct);
      if (!in_valid || in_acc) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: input transaction -> prediction, output transaction -> check
  always @(posedge clk) begin
    out_t e;
    int   errs;
    logic act;
    errs = 0;
    act  = 1'b0;
    if (rst_n) begin
      in_acc <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        rotated_q.push_back(rotate_vec(in_data));
        n_sent <= n_sent + 1;
        act = 1'b1;
      end
      if (out_valid && !out_stall) begin
        act = 1'b1;
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errs = errs + 1;
        end else begin
          e = rotated_q.pop_front();
          n_checked <= n_checked + 1;
          if (e.rot_x !== out_data.rot_x) begin
            $display("%0t: rot_x exp %0d got %0d", $realtime, e.rot_x, out_data.rot_x);
            errs = errs + 1;
          end
          if (e.rot_y !== out_data.rot_y) begin
            $display("%0t: rot_y exp %0d got %0d", $realtime, e.rot_y, out_data.rot_y);
            errs = errs + 1;
          end
          if (e.rot_z !== out_data.rot_z) begin
            $display("%0t: rot_z exp %0d got %0d", $realtime, e.rot_z, out_data.rot_z);
            errs = errs + 1;
          end
        end
      end
      n_errors <= n_errors + errs;
      wdog <= act ? 0 : wdog + 1;
      if (wdog >= WdogMax) begin
        $display("FAIL axis_angle_vector_rotation");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [19:0] rand_angle();
    case ($urandom_range(4))
      0: return 20'($signed($urandom_range(2 * AngMax)) - AngMax);
      1: return 20'($signed($urandom_range(210000)) - 105000);
      2: return $urandom_range(1) ? 20'(AngMax) : 20'(-AngMax);
      default: return 20'($signed($urandom_range(2 * AngMax)) - AngMax);
    endcase
  endfunction

  task automatic push_item(logic [19:0] ang, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
    in_t it;
    it.angle = ang;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && rotated_q.size() == 0);
    @(negedge clk);
    while (in_valid || rotated_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_axis(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= 18'(val);
    axis[idx] = longint'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_axis(int ux, int uy, int uz);
    write_axis(REG_AXIS_X, ux);
    write_axis(REG_AXIS_Y, uy);
    write_axis(REG_AXIS_Z, uz);
  endtask

  task automatic run_random(int n, int idle, int stall);
    src_idle_pct  = idle;
    dst_stall_pct = stall;
    for (int k = 0; k < n; k++) push_item(rand_angle(), rand_coord(), rand_coord(),
                                          rand_coord());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_AXIS_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    in_acc = 1'b0;
    out_stall = 1'b0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    wdog = 0;
    axis[0] = 0;
    axis[1] = 0;
    axis[2] = 65536;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset axis, angle and coordinate extremes, wrap, saturation
    push_item(20'd0, 32'h00010000, 32'h00020000, 32'h00030000);
    push_item(20'(AngMax), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_item(20'(-AngMax), 32'h80000000, 32'h80000000, 32'h80000000);
    push_item(20'd102944, 32'h00010000, 32'h0, 32'h0);
    push_item(20'(-102944), 32'h0, 32'h00010000, 32'h0);
    push_item(20'd205887, 32'h7fffffff, 32'h80000000, 32'h0);
    push_item(20'h7ffff, 32'hffffffff, 32'h00000001, 32'h55555555);
    push_item(20'h80000, 32'haaaaaaaa, 32'h55555555, 32'hffffffff);
    drain();
    // oversized axis drives results into saturation
    set_axis(131071, -131072, 65536);
    push_item(20'd51472, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    push_item(20'(-205887), 32'h40000000, 32'hc0000000, 32'h40000000);
    push_item(20'd300000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    drain();
    // wait out the pipeline before touching the axis again
    repeat (Latency + 4) @(negedge clk);

    set_axis(65536, 0, 0);
    run_random(200, 0, 0);
    set_axis(-65536, 0, 0);
    run_random(200, 45, 0);
    set_axis(0, 65536, 0);
    run_random(200, 0, 45);
    set_axis(37837, 37837, 37837);
    run_random(250, 35, 35);
    set_axis(0, 0, -65536);
    run_random(100, 0, 0);
    set_axis(-131072, 131071, -131072);
    run_random(150, 35, 35);
    set_axis(int'($urandom_range(131072)) - 65536, int'($urandom_range(131072)) - 65536,
             int'($urandom_range(131072)) - 65536);
    run_random(200, 20, 20);

    repeat (Latency + 10) @(negedge clk);
    $display("covered %0d of %0d rotations over nine axis settings, incl. saturation",
             n_checked, n_sent);
    $display("and angle wrap, with sender gaps and receiver stalls");
    if (n_errors == 0 && rotated_q.size() == 0) begin
      $display("PASS axis_angle_vector_rotation");
    end else begin
      $display("FAIL axis_angle_vector_rotation");
    end
    $finish;
  end

endmodule

`default_nettype wire
